[rtl/core/erf_fp32_piecewise_poly_unit_assert.svh]
// Assertion macros for the erf unit.
// Expects clk and arst_n in the scope of use; compiles to nothing under SYNTHESIS.
`ifndef ERF_FP32_PIECEWISE_POLY_UNIT_ASSERT_SVH
`define ERF_FP32_PIECEWISE_POLY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ERF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("erf unit: same-cycle check failed");
`define ERF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("erf unit: next-cycle check failed");
`else
`define ERF_ASSERT_IMPL(lbl, ante, cons)
`define ERF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/erf_pkg.sv]
// Shared types, thresholds and coefficient tables for the erf unit.
// No dependencies.
package erf_pkg;

	// input classification thresholds, on the magnitude bits
	localparam logic [30:0] MAG_INF   = 31'h7F800000;
	localparam logic [30:0] MAG_LARGE = 31'h407547CB;  // 3.8325068950653076171875
	localparam logic [30:0] MAG_T08   = 31'h3F4CCCCD;  // 0.8f
	localparam logic [30:0] MAG_T175  = 31'h3FE00000;  // 1.75f
	localparam logic [30:0] MAG_T28   = 31'h40333333;  // 2.8f
	localparam logic [31:0] ONE_BITS  = 32'h3F800000;

	localparam int unsigned NUM_OPS    = 14;  // offset, six Horner steps, final op
	localparam int unsigned POLY_TERMS = 7;

	typedef enum logic [1:0] {SEG_P0, SEG_P1, SEG_P2, SEG_P3} seg_t;

	// context carried alongside each request through the pipeline
	typedef struct packed {
		logic        valid;
		seg_t        seg;
		logic        sign;
		logic        spec;
		logic [31:0] spec_bits;
		logic [31:0] a;
		logic [31:0] t;
	} side_t;

	typedef struct packed {
		logic en;
		logic last_valid;
	} back_stat_t;

	// fp unit stage records
	typedef struct packed {
		logic               sign;
		logic signed [11:0] etop;  // biased exponent if mant msb sits at bit 47
		logic [47:0]        mant;
	} raw_t;

	typedef struct packed {
		logic        sign;
		logic        zero;
		logic [7:0]  eo;
		logic [23:0] m24;
		logic        g;
		logic        st;
	} nrm_t;

	// real to binary32, round to nearest even; normal values only
	function automatic logic [31:0] f32_of(input real r);
		logic [63:0] d;
		logic [10:0] e11;
		logic [7:0]  e8;
		logic        inc;
		d   = $realtobits(r);
		e11 = d[62:52];
		e8  = 8'(int'(e11) - 1023 + 127);
		inc = d[28] & ((|d[27:0]) | d[29]);
		return {d[63], e8, d[51:29]} + {31'b0, inc};
	endfunction

	localparam logic [31:0] COEF [4][POLY_TERMS] = '{
		'{f32_of(1.128379453136), f32_of(-0.340827090e-4), f32_of(-0.3754641048231),
		  f32_of(-0.480089943431e-2), f32_of(0.1291708894549),
		  f32_of(-0.2738900335275e-1), f32_of(-0.7265839921372e-2)},
		'{f32_of(0.1572988043812), f32_of(-0.4151063740764), f32_of(0.4151681759610),
		  f32_of(-0.1386338728462), f32_of(-0.6996173760407e-1),
		  f32_of(0.7588668092134e-1), f32_of(-0.1999414841696e-1)},
		'{f32_of(0.4677923940847e-2), f32_of(-0.2066698149162e-1),
		  f32_of(0.4131261993220e-1), f32_of(-0.4814201425671e-1),
		  f32_of(0.3459644561569e-1), f32_of(-0.1449449409692e-1),
		  f32_of(0.2739553512239e-2)},
		'{f32_of(0.221830562446e-4), f32_of(-0.140925585762e-3),
		  f32_of(0.420115643592e-3), f32_of(-0.743785588448e-3),
		  f32_of(0.804037923904e-3), f32_of(-0.488747786554e-3),
		  f32_of(0.127400179584e-3)}
	};

	// negated interval offset; -0 leaves a unchanged for the first interval
	function automatic logic [31:0] seg_offset(input seg_t s);
		logic [31:0] v;
		unique case (s)
			SEG_P0:  v = 32'h80000000;
			SEG_P1:  v = 32'hBF800000;
			SEG_P2:  v = 32'hC0000000;
			default: v = 32'hC0400000;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/erf_fifo.sv]
// Small register FIFO used between front and back and on the result side.
// No dependencies.
module erf_fifo #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[rtl/core/erf_front.sv]
// Front end: takes operands, classifies special cases and picks the interval.
// Depends on erf_pkg.
module erf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [31:0]         x_bits,
	output logic                ready,
	input  logic                q_full,
	output logic                q_push,
	output erf_pkg::side_t      q_side
);
	logic        v_s1;
	logic [31:0] x_s1;
	logic [30:0] mag;
	logic        nan;
	logic        big;

	assign ready  = !v_s1 || !q_full;
	assign q_push = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && ready) begin
			x_s1 <= x_bits;
		end
	end

	// classification
	always_comb begin
		mag   = x_s1[30:0];
		nan   = mag > erf_pkg::MAG_INF;
		big   = mag > erf_pkg::MAG_LARGE;
		q_side.valid     = 1'b1;
		q_side.sign      = x_s1[31];
		q_side.spec      = nan || big;
		q_side.spec_bits = nan ? x_s1 : {x_s1[31], erf_pkg::ONE_BITS[30:0]};
		q_side.a         = {1'b0, mag};
		q_side.t         = '0;
		if (mag < erf_pkg::MAG_T08) begin
			q_side.seg = erf_pkg::SEG_P0;
		end else if (mag < erf_pkg::MAG_T175) begin
			q_side.seg = erf_pkg::SEG_P1;
		end else if (mag < erf_pkg::MAG_T28) begin
			q_side.seg = erf_pkg::SEG_P2;
		end else begin
			q_side.seg = erf_pkg::SEG_P3;
		end
	end
endmodule

[rtl/core/erf_fpu.sv]
// Three-stage binary32 multiply-or-add unit, round to nearest even, with context.
// Depends on erf_pkg.
module erf_fpu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                is_mul,
	input  logic [31:0]         op_a,
	input  logic [31:0]         op_b,
	input  erf_pkg::side_t      sb_in,
	output logic [31:0]         res,
	output erf_pkg::side_t      sb_out
);
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	logic           v_s1, v_s2, v_s3;
	erf_pkg::side_t sb_s1, sb_s2, sb_s3;
	erf_pkg::raw_t  raw_c, raw_s1;
	erf_pkg::nrm_t  nrm_c, nrm_s2;
	logic [31:0]    res_c, res_s3;

	// stage A: product, or aligned sum with guard, round and sticky bits
	logic [7:0]  ea, eb, eae, ebe, eg, el, d;
	logic [23:0] fa, fb, fg, fl;
	logic        sg, sl, a_big, st_a;
	logic [26:0] mb, ms, ext;
	logic [27:0] rsum;
	always_comb begin
		ea  = op_a[30:23];
		eb  = op_b[30:23];
		fa  = {ea != 8'd0, op_a[22:0]};
		fb  = {eb != 8'd0, op_b[22:0]};
		eae = (ea == 8'd0) ? 8'd1 : ea;
		ebe = (eb == 8'd0) ? 8'd1 : eb;
		a_big = op_a[30:0] >= op_b[30:0];
		sg  = a_big ? op_a[31] : op_b[31];
		sl  = a_big ? op_b[31] : op_a[31];
		eg  = a_big ? eae : ebe;
		el  = a_big ? ebe : eae;
		fg  = a_big ? fa : fb;
		fl  = a_big ? fb : fa;
		d   = eg - el;
		ext = {fl, 3'b000};
		if (d >= 8'd27) begin
			ms   = '0;
			st_a = |fl;
		end else begin
			ms   = ext >> d;
			st_a = |(ext & ((27'd1 << d) - 27'd1));
		end
		ms[0] = ms[0] | st_a;
		mb    = {fg, 3'b000};
		rsum  = (sg ^ sl) ? ({1'b0, mb} - {1'b0, ms}) : ({1'b0, mb} + {1'b0, ms});
		if (is_mul) begin
			raw_c.sign = op_a[31] ^ op_b[31];
			raw_c.etop = $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd126;
			raw_c.mant = 48'(fa) * 48'(fb);
		end else begin
			raw_c.sign = (rsum == '0) ? (op_a[31] & op_b[31]) : sg;
			raw_c.etop = $signed({4'b0, eg}) + 12'sd1;
			raw_c.mant = {rsum, 20'b0};
		end
	end

	// stage B: leading-zero count and normalize, denormalize below the minimum
	logic [5:0]         lz;
	logic signed [11:0] diff, sh;
	logic [47:0]        nrm;
	logic               st_r;
	always_comb begin
		lz   = lzc48(raw_s1.mant);
		diff = raw_s1.etop - $signed({6'b0, lz});
		sh   = '0;
		st_r = 1'b0;
		nrm_c.eo = 8'd0;
		if (diff >= 12'sd1) begin
			nrm      = raw_s1.mant << lz;
			nrm_c.eo = diff[7:0];
		end else if (raw_s1.etop >= 12'sd1) begin
			sh  = raw_s1.etop - 12'sd1;
			nrm = raw_s1.mant << sh[5:0];
		end else begin
			sh = 12'sd1 - raw_s1.etop;
			if (sh >= 12'sd48) begin
				nrm  = '0;
				st_r = |raw_s1.mant;
			end else begin
				nrm  = raw_s1.mant >> sh[5:0];
				st_r = |(raw_s1.mant & ((48'd1 << sh[5:0]) - 48'd1));
			end
		end
		nrm_c.sign = raw_s1.sign;
		nrm_c.zero = (raw_s1.mant == '0);
		nrm_c.m24  = nrm[47:24];
		nrm_c.g    = nrm[23];
		nrm_c.st   = (|nrm[22:0]) | st_r;
	end

	// stage C: round; a carry moves into the exponent field
	logic        inc;
	logic [30:0] body;
	always_comb begin
		inc   = nrm_s2.g & (nrm_s2.st | nrm_s2.m24[0]);
		body  = {nrm_s2.eo, nrm_s2.m24[22:0]} + {30'b0, inc};
		res_c = nrm_s2.zero ? {nrm_s2.sign, 31'b0} : {nrm_s2.sign, body};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sb_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= raw_c;
			sb_s1  <= sb_in;
			nrm_s2 <= nrm_c;
			sb_s2  <= sb_s1;
			res_s3 <= res_c;
			sb_s3  <= sb_s2;
		end
	end

	assign res = res_s3;
	always_comb begin
		sb_out       = sb_s3;
		sb_out.valid = v_s3;
	end
endmodule

[rtl/core/erf_back.sv]
// Back end: offset, six Horner steps and the final multiply or subtract from one.
// Depends on erf_pkg and erf_fpu.
module erf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  erf_pkg::side_t       in_side,
	output logic                 in_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output logic [31:0]          out_bits,
	output erf_pkg::back_stat_t  stat
);
	localparam int unsigned LAST = erf_pkg::NUM_OPS - 1;

	erf_pkg::side_t sb_in  [erf_pkg::NUM_OPS];
	erf_pkg::side_t sb_out [erf_pkg::NUM_OPS];
	logic [31:0]    opa    [erf_pkg::NUM_OPS];
	logic [31:0]    opb    [erf_pkg::NUM_OPS];
	logic [31:0]    res    [erf_pkg::NUM_OPS];
	logic           is_mul [erf_pkg::NUM_OPS];
	logic           en;

	// one global advance; stall only when a finished result has no room
	assign en     = !(out_full && sb_out[LAST].valid);
	assign in_pop = en && in_valid;

	for (genvar k = 0; k < erf_pkg::NUM_OPS; k++) begin : g_op
		if (k == 0) begin : g_offset
			// t = a - k for the chosen interval
			always_comb begin
				sb_in[k]       = in_side;
				sb_in[k].valid = in_valid;
				opa[k]         = in_side.a;
				opb[k]         = erf_pkg::seg_offset(in_side.seg);
				is_mul[k]      = 1'b0;
			end
		end else if (k == LAST) begin : g_final
			// a * p0, or 1 - p
			always_comb begin
				sb_in[k] = sb_out[k-1];
				if (sb_out[k-1].seg == erf_pkg::SEG_P0) begin
					is_mul[k] = 1'b1;
					opa[k]    = sb_out[k-1].a;
					opb[k]    = res[k-1];
				end else begin
					is_mul[k] = 1'b0;
					opa[k]    = erf_pkg::ONE_BITS;
					opb[k]    = {~res[k-1][31], res[k-1][30:0]};
				end
			end
		end else if ((k % 2) == 1) begin : g_mul
			// t * acc; the first step seeds acc with the top coefficient
			always_comb begin
				sb_in[k]  = sb_out[k-1];
				is_mul[k] = 1'b1;
				if (k == 1) begin
					sb_in[k].t = res[k-1];
					opa[k]     = res[k-1];
					opb[k]     = erf_pkg::COEF[sb_out[k-1].seg][erf_pkg::POLY_TERMS-1];
				end else begin
					opa[k] = sb_out[k-1].t;
					opb[k] = res[k-1];
				end
			end
		end else begin : g_add
			localparam int unsigned CI = 5 - (k - 2) / 2;
			always_comb begin
				sb_in[k]  = sb_out[k-1];
				is_mul[k] = 1'b0;
				opa[k]    = res[k-1];
				opb[k]    = erf_pkg::COEF[sb_out[k-1].seg][CI];
			end
		end

		erf_fpu u_fpu (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.is_mul (is_mul[k]),
			.op_a   (opa[k]),
			.op_b   (opb[k]),
			.sb_in  (sb_in[k]),
			.res    (res[k]),
			.sb_out (sb_out[k])
		);
	end

	// special cases bypass the arithmetic; sign of x goes on the result
	assign out_push = en && sb_out[LAST].valid;
	assign out_bits = sb_out[LAST].spec ? sb_out[LAST].spec_bits
	                                    : {sb_out[LAST].sign, res[LAST][30:0]};
	assign stat.en         = en;
	assign stat.last_valid = sb_out[LAST].valid;
endmodule

[rtl/core/erf_fp32_piecewise_poly_unit.sv]
// erf(x) on binary32 bit patterns, single clock domain.
// Input side is a queue: drive x_bits and raise push; the operand is taken on a
// rising edge with push high and full low. Result side is a queue too: erf_bits
// holds the oldest result while empty is low, and pop on such an edge takes it.
// One operand per cycle is accepted for as long as results are drained.
// From accept to empty going low: the classify register takes the operand at
// the accepting edge, it passes the front queue, then 14 floating-point
// operations of three register stages each (offset, six multiply/add Horner
// steps, final step), then the result queue. The fp unit chain is most of
// that path; the rate is one item per cycle while results are drained.
// NaN inputs come back unchanged, |x| above 3.8325 gives exactly +/-1.
// When pop stays low the result queue fills, the arithmetic pipeline holds
// in place, then the front queue fills and full rises; nothing is dropped.
// Reset clears all queues and valid bits; the block is ready right after.
// Depends on erf_pkg, erf_front, erf_fifo, erf_back and the assertion header.
`include "erf_fp32_piecewise_poly_unit_assert.svh"
module erf_fp32_piecewise_poly_unit #(
	parameter int unsigned MID_DEPTH = 4,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] x_bits,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] erf_bits
);
	localparam int unsigned SIDE_W = $bits(erf_pkg::side_t);

	logic                front_ready;
	logic                front_push;
	erf_pkg::side_t      front_side;
	logic                mid_full, mid_empty, mid_pop;
	logic [SIDE_W-1:0]   mid_dout;
	logic                out_full, out_push;
	logic [31:0]         out_bits;
	erf_pkg::back_stat_t bstat;

	assign full = !front_ready;

	erf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.x_bits (x_bits),
		.ready  (front_ready),
		.q_full (mid_full),
		.q_push (front_push),
		.q_side (front_side)
	);

	erf_fifo #(.WIDTH(SIDE_W), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    (front_side),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	erf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_side  (erf_pkg::side_t'(mid_dout)),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_bits (out_bits),
		.stat     (bstat)
	);

	erf_fifo #(.WIDTH(32), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_bits),
		.full   (out_full),
		.pop    (pop),
		.dout   (erf_bits),
		.empty  (empty)
	);

	// a stalled finished result stays in the last stage
	`ERF_ASSERT_NEXT(a_last_held, bstat.last_valid && !bstat.en, bstat.last_valid)
	// results only move into the output queue when it has room
	`ERF_ASSERT_IMPL(a_out_room, out_push, !out_full)
	// the back end never draws from an empty front queue
	`ERF_ASSERT_IMPL(a_mid_pop, mid_pop, !mid_empty)
	// the front never pushes into a full queue
	`ERF_ASSERT_IMPL(a_mid_room, front_push, !mid_full)
endmodule
